// File: rtl/lams_pkg.sv
package lams_pkg;

  localparam int MODE_COUNT = 9;

  typedef logic [3:0] mode_t;

  localparam mode_t MOD_FSK2  = 4'd0;
  localparam mode_t MOD_FSK4  = 4'd1;
  localparam mode_t MOD_FSK8  = 4'd2;
  localparam mode_t MOD_FSK16 = 4'd3;
  localparam mode_t MOD_BPSK  = 4'd4;
  localparam mode_t MOD_QPSK  = 4'd5;
  localparam mode_t MOD_PSK8  = 4'd6;
  localparam mode_t MOD_QAM16 = 4'd7;
  localparam mode_t MOD_QAM64 = 4'd8;

  localparam logic [0:0] REG_ADAPT_ENABLE = 1'd0;
  localparam logic [0:0] REG_HYSTERESIS   = 1'd1;

  // quality margin for downgrade: 0.2 in 2^-16 units
  localparam logic [16:0] QUALITY_MARGIN = 17'd13107;

  // SNR in 1/16 dB, BER in 2^-20, quality in 2^-16
  typedef struct packed {
    logic signed [12:0] snr_lo;
    logic signed [12:0] snr_hi;
    logic [20:0]        ber_hi;
    logic [16:0]        q_lo;
    logic [13:0]        rate;
  } mode_entry_t;

  // modes in falling rate order; equal rates keep their scan position
  localparam mode_t SCAN_ORDER [MODE_COUNT] = '{
    MOD_QAM64, MOD_QAM16, MOD_FSK16, MOD_PSK8, MOD_FSK8,
    MOD_QPSK, MOD_FSK4, MOD_BPSK, MOD_FSK2
  };

  function automatic mode_entry_t mode_entry(mode_t m);
    mode_entry_t e;
    unique case (m)
      MOD_FSK2:  e = '{13'sd0,   13'sd240, 21'd10486, 17'd19661, 14'd1200};
      MOD_FSK4:  e = '{13'sd128, 13'sd320, 21'd5243,  17'd32768, 14'd2400};
      MOD_FSK8:  e = '{13'sd192, 13'sd400, 21'd1049,  17'd45875, 14'd3600};
      MOD_FSK16: e = '{13'sd288, 13'sd480, 21'd524,   17'd52429, 14'd4800};
      MOD_BPSK:  e = '{13'sd96,  13'sd288, 21'd10486, 17'd26214, 14'd1200};
      MOD_QPSK:  e = '{13'sd160, 13'sd352, 21'd5243,  17'd39322, 14'd2400};
      MOD_PSK8:  e = '{13'sd224, 13'sd416, 21'd1049,  17'd49152, 14'd3600};
      MOD_QAM16: e = '{13'sd256, 13'sd448, 21'd524,   17'd52429, 14'd4800};
      MOD_QAM64: e = '{13'sd352, 13'sd560, 21'd105,   17'd58982, 14'd9600};
      default:   e = '{13'sd0,   13'sd240, 21'd10486, 17'd19661, 14'd1200};
    endcase
    return e;
  endfunction

endpackage

// File: rtl/lams_pick.sv
module lams_pick (
  input  logic signed [11:0] snr,
  input  logic [20:0]        bit_error_rate,
  output lams_pkg::mode_t    pick
);
  import lams_pkg::*;

  logic [MODE_COUNT-1:0] qualify;
  logic signed [12:0]    snr_ext;

  assign snr_ext = 13'(snr);

  // nine window checks in parallel
  always_comb begin
    mode_entry_t e;
    for (int i = 0; i < MODE_COUNT; i++) begin
      e = mode_entry(4'(i));
      qualify[i] = (snr_ext >= e.snr_lo) && (snr_ext <= e.snr_hi) &&
                   (bit_error_rate <= e.ber_hi);
    end
  end

  // first qualifying mode in scan order wins; fall back to 2FSK
  always_comb begin
    pick = MOD_FSK2;
    for (int i = MODE_COUNT - 1; i >= 0; i--) begin
      if (qualify[SCAN_ORDER[i]]) begin
        pick = SCAN_ORDER[i];
      end
    end
  end

endmodule

// File: rtl/link_adaptation_mode_select_unit.sv
// Path: an accepted item goes through the input register, then the decision
// into the result register; an output stall can hold it in the input register.
// Throughput: one item per cycle while the output is not stalled; the mode
// state is updated in the same cycle as the result register, so the next
// item sees it at once. Reset: clears both pipeline valids, the held mode
// and prior mode to 2FSK, adapt_enable to 1 and hysteresis to 32.
module link_adaptation_mode_select_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic signed [11:0]  snr,
  input  logic [20:0]         bit_error_rate,
  input  logic [16:0]         quality,
  input  logic [3:0]          new_mode,
  output logic                out_valid,
  input  logic                out_stall,
  output lams_pkg::mode_t     mode,
  output logic [13:0]         data_rate,
  output logic                mode_changed,
  output lams_pkg::mode_t     previous_mode
);
  import lams_pkg::*;

  logic               adapt_enable;
  logic [8:0]         hysteresis;
  mode_t              cur_mode;
  mode_t              prior_mode;

  logic               s1_valid;
  logic               s1_action;
  logic signed [11:0] s1_snr;
  logic [20:0]        s1_ber;
  logic [16:0]        s1_quality;
  logic [3:0]         s1_new_mode;

  logic               out_free;
  logic               s1_fire;
  mode_t              rec_mode;
  mode_entry_t        cur_entry;
  mode_entry_t        next_entry;
  mode_entry_t        out_entry;
  logic signed [12:0] snr_ext;
  logic signed [12:0] snr_up;
  logic signed [12:0] snr_down;
  logic [16:0]        q_down;
  logic               go_up;
  logic               go_down;
  mode_t              cur_mode_next;
  mode_t              prior_mode_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      adapt_enable <= 1'b1;
      hysteresis   <= 9'd32;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ADAPT_ENABLE: adapt_enable <= cfg_data[0];
        REG_HYSTERESIS:   hysteresis   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action   <= action;
      s1_snr      <= snr;
      s1_ber      <= bit_error_rate;
      s1_quality  <= quality;
      s1_new_mode <= new_mode;
    end
  end

  lams_pick u_pick (
    .snr            (s1_snr),
    .bit_error_rate (s1_ber),
    .pick           (rec_mode)
  );

  assign cur_entry = mode_entry(cur_mode);
  assign snr_ext   = 13'(s1_snr);
  assign snr_up    = cur_entry.snr_hi + $signed({4'b0, hysteresis});
  assign snr_down  = cur_entry.snr_lo - $signed({4'b0, hysteresis});
  assign q_down    = cur_entry.q_lo - QUALITY_MARGIN;

  assign go_up   = (snr_ext > snr_up) && (s1_ber < cur_entry.ber_hi) &&
                   (s1_quality > cur_entry.q_lo);
  assign go_down = (snr_ext < snr_down) || (s1_ber > cur_entry.ber_hi) ||
                   (s1_quality < q_down);

  always_comb begin
    cur_mode_next   = cur_mode;
    prior_mode_next = prior_mode;
    if (s1_action) begin
      // drop a force to an unknown mode
      if (s1_new_mode < 4'(MODE_COUNT)) begin
        cur_mode_next   = s1_new_mode;
        prior_mode_next = s1_new_mode;
      end
    end else if (adapt_enable && (go_up || go_down) && (rec_mode != cur_mode)) begin
      cur_mode_next   = rec_mode;
      prior_mode_next = cur_mode;
    end
  end

  assign next_entry = mode_entry(cur_mode_next);
  assign out_entry  = mode_entry(mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode   <= MOD_FSK2;
      prior_mode <= MOD_FSK2;
    end else if (s1_fire) begin
      cur_mode   <= cur_mode_next;
      prior_mode <= prior_mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mode          <= cur_mode_next;
      data_rate     <= next_entry.rate;
      mode_changed  <= (cur_mode_next != cur_mode);
      previous_mode <= prior_mode_next;
    end
  end

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mode < 4'(MODE_COUNT)))
    else $error("result mode out of range");

  a_mode_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mode == cur_mode))
    else $error("result mode differs from held mode");

  a_rate_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (data_rate == out_entry.rate))
    else $error("data rate does not match mode");

  a_frozen_report: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_action && !adapt_enable) |=> !mode_changed)
    else $error("report changed mode while adaptation disabled");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

endmodule
